/* design/base32_decoder_validator_core_defines.svh */
// assertion macros for the base32 decoder validator
`ifndef BASE32_DECODER_VALIDATOR_CORE_DEFINES_SVH
`define BASE32_DECODER_VALIDATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define B32DV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define B32DV_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define B32DV_ASSERT(lbl, clk, rst_n, prop, msg)
`define B32DV_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* design/b32dv_pkg.sv */
package b32dv_pkg;

  // status codes carried on every result
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_CHAR       = 3'd1,
    ST_BAD_PAD_POS    = 3'd2,
    ST_CHAR_AFTER_PAD = 3'd3,
    ST_BAD_LENGTH     = 3'd4
  } status_e;

  // classified character as queued between front and back
  typedef struct packed {
    logic [4:0] value;
    logic       is_pad;
    logic       is_bad;
    logic       final_char;
  } class_t;

endpackage

/* design/b32dv_front.sv */
module b32dv_front
  import b32dv_pkg::*;
(
  input  logic [7:0] character_i,
  input  logic       final_char_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output class_t     q_data_o
);

  localparam logic [7:0] CharPad = 8'h3D;

  logic [7:0] diff_upper;
  logic [7:0] diff_lower;
  logic [7:0] diff_digit;

  always_comb begin
    diff_upper = character_i - 8'h41;
    diff_lower = character_i - 8'h61;
    diff_digit = character_i - 8'h18; // '2' maps to 26
    q_data_o.final_char = final_char_i;
    q_data_o.is_pad     = (character_i == CharPad);
    q_data_o.is_bad     = 1'b0;
    q_data_o.value      = 5'd0;
    if (character_i >= 8'h41 && character_i <= 8'h5A) begin
      q_data_o.value = diff_upper[4:0];
    end else if (character_i >= 8'h61 && character_i <= 8'h7A) begin
      q_data_o.value = diff_lower[4:0];
    end else if (character_i >= 8'h32 && character_i <= 8'h37) begin
      q_data_o.value = diff_digit[4:0];
    end else if (character_i == 8'h30) begin
      q_data_o.value = 5'd14; // '0' read as O
    end else if (character_i == 8'h31) begin
      q_data_o.value = 5'd11; // '1' read as L
    end else if (character_i == 8'h38) begin
      q_data_o.value = 5'd1;  // '8' read as B
    end else if (character_i != CharPad) begin
      q_data_o.is_bad = 1'b1;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

/* design/b32dv_fifo.sv */
`include "base32_decoder_validator_core_defines.svh"

module b32dv_fifo
  import b32dv_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  class_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output class_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  class_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  `B32DV_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `B32DV_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")
  `B32DV_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(Depth), "queue count overrun")

endmodule

/* design/b32dv_back.sv */
`include "base32_decoder_validator_core_defines.svh"

module b32dv_back
  import b32dv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  class_t     q_data_i,
  output logic       q_pop_o,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic [2:0] status_o,
  output logic       end_of_string_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic [11:0] bit_buffer_q, bit_buffer_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [2:0]  group_pos_q, group_pos_d;
  logic        pad_seen_q, pad_seen_d;
  status_e     error_q, error_d;

  logic        out_valid_q;
  logic [7:0]  data_byte_q, data_byte_d;
  logic        byte_valid_q, byte_valid_d;
  status_e     status_q, status_d;
  logic        eos_q;

  status_e     err;
  logic [11:0] buf_new;
  logic [3:0]  cnt_sum;
  logic [3:0]  cnt_left;
  logic [11:0] buf_shifted;
  logic [2:0]  gp_next;
  logic        pad_pos_ok;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    bit_buffer_d = bit_buffer_q;
    bit_count_d  = bit_count_q;
    pad_seen_d   = pad_seen_q;
    err          = ST_OK;
    data_byte_d  = 8'd0;
    byte_valid_d = 1'b0;
    buf_new      = {bit_buffer_q[6:0], q_data_i.value};
    cnt_sum      = bit_count_q + 4'd5;
    cnt_left     = cnt_sum - 4'd8;
    buf_shifted  = buf_new >> cnt_left;
    gp_next      = group_pos_q + 3'd1;
    pad_pos_ok   = (group_pos_q == 3'd2) || (group_pos_q == 3'd4) ||
                   (group_pos_q == 3'd5) || (group_pos_q == 3'd7);

    if (pad_seen_q) begin
      if (!q_data_i.is_pad) begin
        err = ST_CHAR_AFTER_PAD;
      end else if (group_pos_q == 3'd0) begin
        err = ST_BAD_PAD_POS;
      end
    end else if (q_data_i.is_pad) begin
      if (!pad_pos_ok) begin
        err = ST_BAD_PAD_POS;
      end else if (error_q == ST_OK) begin
        pad_seen_d = 1'b1;
      end
    end else if (q_data_i.is_bad) begin
      err = ST_BAD_CHAR;
    end else if (error_q == ST_OK) begin
      bit_buffer_d = buf_new;
      bit_count_d  = cnt_sum;
      if (cnt_sum >= 4'd8) begin
        bit_count_d  = cnt_left;
        data_byte_d  = buf_shifted[7:0];
        byte_valid_d = 1'b1;
      end
    end

    error_d = (error_q == ST_OK && err != ST_OK) ? err : error_q;
    group_pos_d = gp_next;

    status_d = error_d;
    if (q_data_i.final_char && error_d == ST_OK && gp_next != 3'd0) begin
      status_d = ST_BAD_LENGTH;
    end

    // end of string: back to reset state
    if (q_data_i.final_char) begin
      bit_buffer_d = '0;
      bit_count_d  = '0;
      group_pos_d  = '0;
      pad_seen_d   = 1'b0;
      error_d      = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_buffer_q <= '0;
      bit_count_q  <= '0;
      group_pos_q  <= '0;
      pad_seen_q   <= 1'b0;
      error_q      <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        bit_buffer_q <= bit_buffer_d;
        bit_count_q  <= bit_count_d;
        group_pos_q  <= group_pos_d;
        pad_seen_q   <= pad_seen_d;
        error_q      <= error_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_byte_q  <= data_byte_d;
      byte_valid_q <= byte_valid_d;
      status_q     <= status_d;
      eos_q        <= q_data_i.final_char;
    end
  end

  assign data_byte_o     = data_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign status_o        = status_q;
  assign end_of_string_o = eos_q;
  assign out_valid_o     = out_valid_q;

  `B32DV_ASSERT(a_count_low, clk_i, rst_ni, bit_count_q < 4'd8, "bit count left at 8 or more")
  `B32DV_NEVER(a_held_code, clk_i, rst_ni,
    error_q == ST_BAD_LENGTH || error_q > ST_BAD_LENGTH, "length code held as error")
  `B32DV_ASSERT(a_byte_ok, clk_i, rst_ni,
    (out_valid_q && byte_valid_q) |->
      (status_q == ST_OK) || (status_q == ST_BAD_LENGTH && eos_q), "byte emitted after error")

endmodule

/* design/base32_decoder_validator_core.sv */
// path: a character beat, once taken, passes through the queue register and then the back stage's
// output register before its result beat appears on the outputs
// throughput: one character beat per cycle while neither side stalls, one result beat per character
// the rate is set by the bit buffer update in the back stage
// reset: rst_ni clears the queue, the decode state and the output register
// state also returns to reset after each beat marked as final
module base32_decoder_validator_core
  import b32dv_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // character channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       final_char_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic [2:0] status_o,
  output logic       end_of_string_o
);

  // front to queue
  logic   q_push;
  logic   q_full;
  class_t q_wdata;
  // queue to back
  logic   q_pop;
  logic   q_valid;
  class_t q_rdata;

  // front: maps each character to its 5-bit value, flags pad and bad characters
  b32dv_front u_front (
    .character_i  (character_i),
    .final_char_i (final_char_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // short queue so that input and output stall independently
  b32dv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  // back: bit packing, padding and length checks, registered result beat
  b32dv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .status_o        (status_o),
    .end_of_string_o (end_of_string_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i)
  );

endmodule

/* tb/base32_decoder_validator_core_test.sv */
module base32_decoder_validator_core_test
  import b32dv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // character codes used by the decode rules
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_1 = 8'h31;
  localparam logic [7:0] CH_DIGIT_2 = 8'h32;
  localparam logic [7:0] CH_DIGIT_7 = 8'h37;
  localparam logic [7:0] CH_DIGIT_8 = 8'h38;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [7:0] CH_BRACE   = 8'h7B;

  localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;       // extra wait after the last expected beat is seen
  localparam int CYCLE_LIMIT  = 400000;

  // one expected result beat
  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    status_e    status;
    logic       end_of_string;
  } decode_result_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] character_i     = 8'h00;
  logic       final_char_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic [2:0] status_o;
  logic       end_of_string_o;

  // predictor state, mirrors the decoder's own
  logic [11:0] gathered_bits = '0;
  logic [3:0]  gathered_count = '0;
  logic [2:0]  group_pos = '0;
  logic        pad_started = 1'b0;
  status_e     first_error = ST_OK;

  decode_result_t decode_results_q[$];
  decode_result_t next_result;

  int  fail_count  = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;
  bit  tx_idle_en  = 1'b0;
  bit  rx_idle_en  = 1'b0;
  bit  hold_req    = 1'b0;

  base32_decoder_validator_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .character_i     (character_i),
    .final_char_i    (final_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .status_o        (status_o),
    .end_of_string_o (end_of_string_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a stuck handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // 5-bit symbol value, or -1 for anything outside the alphabet
  function automatic int alphabet_index(logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c) - int'(CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c) - int'(CH_LOWER_A);
    if (c >= CH_DIGIT_2 && c <= CH_DIGIT_7) return int'(c) - int'(CH_DIGIT_2) + 26;
    // aliases: 0 reads as O, 1 as L, 8 as B
    if (c == CH_DIGIT_0) return 14;
    if (c == CH_DIGIT_1) return 11;
    if (c == CH_DIGIT_8) return 1;
    return -1;
  endfunction

  // work out the result beat for one accepted character and queue it
  task automatic decode_char(input logic [7:0] c, input logic fin);
    decode_result_t r;
    status_e        err;
    int             sym;
    r.data_byte  = 8'h00;
    r.byte_valid = 1'b0;
    err          = ST_OK;
    if (pad_started) begin
      // only more padding may follow, and it must not open a new group
      if (c != CH_PAD) err = ST_CHAR_AFTER_PAD;
      else if (group_pos == 3'd0) err = ST_BAD_PAD_POS;
    end else if (c == CH_PAD) begin
      if (group_pos inside {3'd2, 3'd4, 3'd5, 3'd7}) begin
        if (first_error == ST_OK) pad_started = 1'b1;
      end else begin
        err = ST_BAD_PAD_POS;
      end
    end else begin
      sym = alphabet_index(c);
      if (sym < 0) begin
        err = ST_BAD_CHAR;
      end else if (first_error == ST_OK) begin
        // msb-first packing, a byte leaves as soon as 8 bits are in
        gathered_bits  = {gathered_bits[6:0], sym[4:0]};
        gathered_count = gathered_count + 4'd5;
        if (gathered_count >= 4'd8) begin
          gathered_count = gathered_count - 4'd8;
          r.data_byte    = 8'(gathered_bits >> gathered_count);
          r.byte_valid   = 1'b1;
        end
      end
    end
    if (first_error == ST_OK && err != ST_OK) first_error = err;
    group_pos = group_pos + 3'd1;
    r.status = first_error;
    if (fin && first_error == ST_OK && group_pos != 3'd0) r.status = ST_BAD_LENGTH;
    r.end_of_string = fin;
    decode_results_q.push_back(r);
    if (fin) begin
      gathered_bits  = '0;
      gathered_count = '0;
      group_pos      = '0;
      pad_started    = 1'b0;
      first_error    = ST_OK;
    end
  endtask

  // offer one character beat, wait until it is taken, then predict
  task automatic send_char(input logic [7:0] c, input logic fin);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    character_i  <= c;
    final_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_char(c, fin);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // any member of the alphabet, both cases and the aliases included
  function automatic logic [7:0] random_symbol();
    int r;
    r = $urandom_range(0, 60);
    if (r < 26) return CH_UPPER_A + 8'(r);
    if (r < 52) return CH_LOWER_A + 8'(r - 26);
    if (r < 58) return CH_DIGIT_2 + 8'(r - 52);
    if (r == 58) return CH_DIGIT_0;
    if (r == 59) return CH_DIGIT_1;
    return CH_DIGIT_8;
  endfunction

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (decode_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor: every beat taken is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decode_results_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, %s %0h valid %b status %0d eos %b",
                 $realtime, "actual byte", data_byte_o, byte_valid_o, status_o,
                 end_of_string_o);
        fail_count++;
      end else begin
        next_result = decode_results_q.pop_front();
        check_field("data_byte", next_result.data_byte, data_byte_o);
        check_field("byte_valid", 8'(next_result.byte_valid), 8'(byte_valid_o));
        check_field("status", 8'(next_result.status), 8'(status_o));
        check_field("end_of_string", 8'(next_result.end_of_string), 8'(end_of_string_o));
      end
    end
  end

  // receiver stall: random bursts, or one long hold-off when asked for
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      out_stall_i <= 1'b1;
      for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk_i);
      out_stall_i <= 1'b0;
      hold_req = 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // one full group across the alphabet extremes, case mix and aliases
  task automatic test_valid_group();
    send_text("AZaz0187");
  endtask

  // padding from position 2, then one more pad that would open a new group
  task automatic test_padding_overrun();
    send_text("7B=======");
  endtask

  // characters outside the alphabet, the brace included
  task automatic test_bad_char();
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_BRACE, 1'b1);
  endtask

  // padding where a group cannot end
  task automatic test_bad_pad_pos();
    send_text("=");
  endtask

  // a symbol once padding has begun
  task automatic test_char_after_pad();
    send_text("AB=C");
  endtask

  // string not a multiple of 8 long, its last beat completes no byte
  task automatic test_bad_length();
    send_text("ABC");
  endtask

  // mostly well-formed strings with random content, some noise
  task automatic test_random_strings(input int n_items);
    int         sent;
    int         len;
    int         pad;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = 8 * $urandom_range(1, 3);
        case ($urandom_range(0, 4))
          0: pad = 0;
          1: pad = 1;
          2: pad = 3;
          3: pad = 4;
          default: pad = 6;
        endcase
        for (int i = 0; i < len; i++) begin
          c = (i >= len - pad) ? CH_PAD : random_symbol();
          send_char(c, i == len - 1);
        end
      end else begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 4))
            0, 1: c = random_symbol();
            2: c = CH_PAD;
            default: c = 8'($urandom_range(0, 255));
          endcase
          send_char(c, i == len - 1);
        end
      end
      sent += len;
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    bit saved_idle;
    saved_idle = tx_idle_en;
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    while (!out_stall_i) @(posedge clk_i);
    test_random_strings(48);
    tx_idle_en = saved_idle;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    test_valid_group();
    test_padding_overrun();
    test_bad_char();
    test_bad_pad_pos();
    test_char_after_pad();
    test_bad_length();
    wait_for_results();

    test_backpressure();
    wait_for_results();

    test_random_strings(520);
    wait_for_results();

    // closing stretch with both sides running flat out
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_strings(200);
    wait_for_results();

    if (fail_count == 0 && decode_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
